### src/grc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants, types and action codes for the reachability closure core.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int MAX_NODES = 32;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int CFG_W     = 6;
    localparam int ACT_W     = 2;

    typedef logic [MAX_NODES-1:0] t_row;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLOSE = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // one port request to a row memory: one write and one read per cycle
    typedef struct packed {
        logic we;
        t_idx waddr;
        t_row wdata;
        t_idx raddr;
    } t_mem_req;

endpackage

### src/grc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_in_if
// Command channel: action plus source and destination node index.
// ----------------------------------------------------------------------------
interface grc_in_if;
    import grc_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] src_node;
    logic [IDX_W-1:0] dest_node;

    modport source (output valid, output action, output src_node, output dest_node,
                    input ready);
    modport sink   (input valid, input action, input src_node, input dest_node,
                    output ready);
endinterface

### src/grc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_out_if
// Result channel: reachability answer and index error flag.
// ----------------------------------------------------------------------------
interface grc_out_if;
    logic valid;
    logic ready;
    logic reachable;
    logic index_error;

    modport source (output valid, output reachable, output index_error, input ready);
    modport sink   (input valid, input reachable, input index_error, output ready);
endinterface

### src/grc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_cfg_if
// Configuration write channel carrying the node count register value.
// ----------------------------------------------------------------------------
interface grc_cfg_if;
    import grc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/grc_rowmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_rowmem
// Bit-matrix row store: one write and one registered read per cycle.
// Per-row valid bits make rows never written since reset read as zero.
// ----------------------------------------------------------------------------
module grc_rowmem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  grc_pkg::t_mem_req i_req,
    output grc_pkg::t_row     o_rdata
);
    import grc_pkg::*;

    t_row                 mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_vld;
    t_row                 r_rdata;
    logic                 r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[i_req.raddr];
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

### src/grc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_ctrl
// Action sequencer: edge read-modify-write, query lookup, and the Warshall
// closure sweep over the two row memories; holds the result word register.
// ----------------------------------------------------------------------------
module grc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  grc_pkg::t_cnt     i_nodes,
    grc_in_if.sink            i_in,
    grc_out_if.source         o_out,
    output grc_pkg::t_mem_req o_adj_req,
    input  grc_pkg::t_row     i_adj_rdata,
    output grc_pkg::t_mem_req o_reach_req,
    input  grc_pkg::t_row     i_reach_rdata
);
    import grc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_EDGE  = 10'b00_0000_0010,
        S_QRY   = 10'b00_0000_0100,
        S_CP_RD = 10'b00_0000_1000,
        S_CP_WR = 10'b00_0001_0000,
        S_K_RD  = 10'b00_0010_0000,
        S_K_LAT = 10'b00_0100_0000,
        S_I_RD  = 10'b00_1000_0000,
        S_I_WR  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    t_idx   r_src, n_src;
    t_idx   r_dest, n_dest;
    t_cnt   r_n, n_n;
    t_cnt   r_i, n_i;
    t_cnt   r_k, n_k;
    t_row   r_rowk, n_rowk;
    logic   r_res_reach, n_res_reach;
    logic   r_res_err, n_res_err;
    logic   r_ovld, n_ovld;
    logic   r_oreach, n_oreach;
    logic   r_oerr, n_oerr;

    logic   accept;
    logic   bad;
    t_row   col_mask;
    t_cnt   i_inc;
    t_cnt   k_inc;

    assign i_in.ready        = (r_state == S_IDLE);
    assign accept            = i_in.valid && i_in.ready;
    assign bad               = ({1'b0, i_in.src_node} >= i_nodes)
                            || ({1'b0, i_in.dest_node} >= i_nodes);
    assign i_inc             = r_i + t_cnt'(1);
    assign k_inc             = r_k + t_cnt'(1);
    assign o_out.valid       = r_ovld;
    assign o_out.reachable   = r_oreach;
    assign o_out.index_error = r_oerr;

    // columns that take part in the closure
    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            col_mask[j] = (t_cnt'(j) < r_n);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_dest      = r_dest;
        n_n         = r_n;
        n_i         = r_i;
        n_k         = r_k;
        n_rowk      = r_rowk;
        n_res_reach = r_res_reach;
        n_res_err   = r_res_err;
        n_ovld      = r_ovld && !o_out.ready;
        n_oreach    = r_oreach;
        n_oerr      = r_oerr;
        o_adj_req   = '0;
        o_reach_req = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_src       = i_in.src_node;
                    n_dest      = i_in.dest_node;
                    n_n         = i_nodes;
                    n_i         = '0;
                    n_k         = '0;
                    n_res_reach = 1'b0;
                    n_res_err   = 1'b0;
                    n_state     = S_DONE;
                    case (t_action'(i_in.action))
                        ACT_ADD: begin
                            if (bad) begin
                                n_res_err = 1'b1;
                            end else if (i_in.src_node != i_in.dest_node) begin
                                o_adj_req.raddr = i_in.src_node;
                                n_state         = S_EDGE;
                            end
                        end
                        ACT_QUERY: begin
                            if (bad) begin
                                n_res_err = 1'b1;
                            end else begin
                                o_reach_req.raddr = i_in.src_node;
                                n_state           = S_QRY;
                            end
                        end
                        ACT_CLOSE: begin
                            n_state = S_CP_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_EDGE: begin
                o_adj_req.we    = 1'b1;
                o_adj_req.waddr = r_src;
                o_adj_req.wdata = i_adj_rdata | (t_row'(1) << r_dest);
                n_state         = S_DONE;
            end
            S_QRY: begin
                n_res_reach = i_reach_rdata[r_dest];
                n_state     = S_DONE;
            end
            S_CP_RD: begin
                o_adj_req.raddr = r_i[IDX_W-1:0];
                n_state         = S_CP_WR;
            end
            S_CP_WR: begin
                // rows outside the live range are cleared
                o_reach_req.we    = 1'b1;
                o_reach_req.waddr = r_i[IDX_W-1:0];
                o_reach_req.wdata = (r_i < r_n) ? (i_adj_rdata & col_mask) : '0;
                if (r_i == t_cnt'(MAX_NODES - 1)) begin
                    n_i     = '0;
                    n_state = (r_n == '0) ? S_DONE : S_K_RD;
                end else begin
                    n_i     = i_inc;
                    n_state = S_CP_RD;
                end
            end
            S_K_RD: begin
                o_reach_req.raddr = r_k[IDX_W-1:0];
                n_state           = S_K_LAT;
            end
            S_K_LAT: begin
                n_rowk  = i_reach_rdata;
                n_i     = '0;
                n_state = S_I_RD;
            end
            S_I_RD: begin
                o_reach_req.raddr = r_i[IDX_W-1:0];
                n_state           = S_I_WR;
            end
            S_I_WR: begin
                if (i_reach_rdata[r_k[IDX_W-1:0]]) begin
                    o_reach_req.we    = 1'b1;
                    o_reach_req.waddr = r_i[IDX_W-1:0];
                    o_reach_req.wdata = i_reach_rdata | r_rowk;
                end
                if (i_inc == r_n) begin
                    n_i = '0;
                    if (k_inc == r_n) begin
                        n_state = S_DONE;
                    end else begin
                        n_k     = k_inc;
                        n_state = S_K_RD;
                    end
                end else begin
                    n_i     = i_inc;
                    n_state = S_I_RD;
                end
            end
            S_DONE: begin
                if (!r_ovld || o_out.ready) begin
                    n_ovld   = 1'b1;
                    n_oreach = r_res_reach;
                    n_oerr   = r_res_err;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_i     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_i     <= n_i;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_dest      <= n_dest;
        r_n         <= n_n;
        r_rowk      <= n_rowk;
        r_res_reach <= n_res_reach;
        r_res_err   <= n_res_err;
        r_oreach    <= n_oreach;
        r_oerr      <= n_oerr;
    end

endmodule

### src/graph_reachability_closure_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_reachability_closure_core
// Directed-graph adjacency store with on-demand boolean transitive closure.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  : node_count write word (always ready); write only while idle.
//            Values above MAX_NODES act as MAX_NODES.
//   i_in   : command word {action, src_node, dest_node}. Add edge sets one
//            adjacency bit, closure rebuilds the reachability matrix,
//            query reads one reachability bit.
//   o_out  : one result word per command {reachable, index_error}.
// Sequencing:
//   Add edge and query: row read on the accept edge, then write-back or bit
//   select, then result load.
//   Out-of-range index or unused action: no memory access, straight to the result load.
//   Closure, for n live nodes, follows the single read/write port pair of
//   the reach row memory: a copy pass over all rows, then per pivot one
//   row read and a read-modify-write per row.
//   One command in flight; ready is high only while the sequencer idles.
// Reset: both matrices read as zero (per-row valid bits), node_count = 32.
// Stall: the result register holds its word until taken; the next command
//   is accepted meanwhile and its result waits in the sequencer.
// ----------------------------------------------------------------------------
module graph_reachability_closure_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    grc_cfg_if.sink   i_cfg,
    grc_in_if.sink    i_in,
    grc_out_if.source o_out
);
    import grc_pkg::*;

    logic [CFG_W-1:0] r_node_count;
    t_cnt             eff_nodes;
    t_mem_req         adj_req;
    t_mem_req         reach_req;
    t_row             adj_rdata;
    t_row             reach_rdata;

    // config register: always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_W'(MAX_NODES);
        end else if (i_cfg.valid) begin
            r_node_count <= i_cfg.data;
        end
    end

    // clamp to the matrix size
    assign eff_nodes = (r_node_count > CFG_W'(MAX_NODES)) ? t_cnt'(MAX_NODES)
                                                          : t_cnt'(r_node_count);

    grc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_nodes       (eff_nodes),
        .i_in          (i_in),
        .o_out         (o_out),
        .o_adj_req     (adj_req),
        .i_adj_rdata   (adj_rdata),
        .o_reach_req   (reach_req),
        .i_reach_rdata (reach_rdata)
    );

    // adjacency matrix, one row per source node
    grc_rowmem u_adj_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (adj_req),
        .o_rdata (adj_rdata)
    );

    // reachability matrix, rebuilt in place by each closure
    grc_rowmem u_reach_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (reach_req),
        .o_rdata (reach_rdata)
    );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for graph_reachability_closure_core. A shadow copy of
// the adjacency and reachability matrices predicts every result word, which
// is checked in order against the core output. The bench drives directed
// edge, closure and query sequences, then random graph traffic over several
// node_count settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import grc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int MAX_GAP      = 8;
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    // sized above the worst closure plus the hold-off and gaps, with margin
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 16;
    localparam int PHASE_ITEMS  = 90;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        t_action act;
        t_idx    src;
        t_idx    dst;
    } t_graph_cmd;

    // expected result word, with the command that caused it for messages
    typedef struct {
        t_graph_cmd cmd;
        logic       reachable;
        logic       index_error;
    } t_graph_answer;

    logic i_clk;
    logic i_rst_n;

    grc_cfg_if cfg_if ();
    grc_in_if  cmd_if ();
    grc_out_if res_if ();

    graph_reachability_closure_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // ------------------------------------------------------------------
    // Shadow graph state
    // ------------------------------------------------------------------
    t_row             shadow_adj   [MAX_NODES];
    t_row             shadow_reach [MAX_NODES];
    logic [CFG_W-1:0] shadow_node_count;

    t_graph_cmd    pending_cmds[$];      // waiting to be offered
    t_graph_answer expected_answers[$];  // accepted, result not yet seen
    t_graph_cmd    offered_cmd;          // word currently on the input channel

    int in_gap;
    int out_gap;
    int hold_left;
    int stall_cycles;
    int mismatches;
    bit in_idle_on;
    bit out_idle_on;
    bit hold_req;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Apply one accepted command to the shadow graph and return its result.
    // Indices at or above the live node count (node_count clipped to
    // MAX_NODES) flag an error on add and query and change nothing.
    function automatic t_graph_answer apply_to_graph(t_graph_cmd c);
        t_graph_answer a;
        int            n;
        int            i;
        int            k;
        logic          bad;
        t_row          live;
        n    = (shadow_node_count > MAX_NODES) ? MAX_NODES : int'(shadow_node_count);
        live = '0;
        for (i = 0; i < n; i++)
            live[i] = 1'b1;
        bad           = (c.src >= n) || (c.dst >= n);
        a.cmd         = c;
        a.reachable   = 1'b0;
        a.index_error = 1'b0;
        case (c.act)
            ACT_ADD: begin
                if (bad)
                    a.index_error = 1'b1;
                else if (c.src != c.dst)
                    shadow_adj[c.src][c.dst] = 1'b1;    // self edges dropped
            end
            ACT_CLOSE: begin
                // only live rows and columns take part; the rest reads zero
                for (i = 0; i < MAX_NODES; i++)
                    shadow_reach[i] = (i < n) ? (shadow_adj[i] & live) : '0;
                for (k = 0; k < n; k++)
                    for (i = 0; i < n; i++)
                        if (shadow_reach[i][k])
                            shadow_reach[i] = shadow_reach[i] | shadow_reach[k];
            end
            ACT_QUERY: begin
                // answers from the last closure, not from the current edges
                if (bad)
                    a.index_error = 1'b1;
                else
                    a.reachable = shadow_reach[c.src][c.dst];
            end
            default: ;    // unused action: no state change, zero result
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Command driver: takes the next pending command once the current
    // word is accepted, after a random gap when sender idling is on.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready)
                expected_answers.insert(expected_answers.size(),
                                        apply_to_graph(offered_cmd));
            if (!cmd_if.valid || cmd_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (pending_cmds.size() == 0) begin
                    cmd_if.valid <= 1'b0;
                end else begin
                    offered_cmd = pending_cmds.pop_front();
                    cmd_if.valid     <= 1'b1;
                    cmd_if.action    <= offered_cmd.act;
                    cmd_if.src_node  <= offered_cmd.src;
                    cmd_if.dest_node <= offered_cmd.dst;
                    in_gap = in_idle_on ? $urandom_range(0, MAX_GAP) : 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each accepted word against the oldest
    // expectation, then draws its own stall before the next word.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_graph_answer want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_answers.size() == 0) begin
                    flag_mismatch("result word with no command outstanding");
                end else begin
                    want = expected_answers.pop_front();
                    if (res_if.reachable !== want.reachable)
                        flag_mismatch($sformatf("%s %0d->%0d: reachable %b, expected %b",
                            want.cmd.act.name(), want.cmd.src, want.cmd.dst,
                            res_if.reachable, want.reachable));
                    if (res_if.index_error !== want.index_error)
                        flag_mismatch($sformatf("%s %0d->%0d: index_error %b, expected %b",
                            want.cmd.act.name(), want.cmd.src, want.cmd.dst,
                            res_if.index_error, want.index_error));
                end
                out_gap = out_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, so the core fills and backs up its input.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Watchdog: too many cycles with no word moving on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("** graph_reachability_closure_core: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_cmd(input t_action a, input int s, input int d);
        t_graph_cmd c;
        c.act = a;
        c.src = t_idx'(s);
        c.dst = t_idx'(d);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Sender pause: nothing pending, nothing on the wire, nothing expected.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_if.valid || expected_answers.size() != 0);
    endtask

    // node_count write; only called with the core idle
    task automatic write_node_count(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do
            @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        shadow_node_count = v;
    endtask

    // One random phase: mostly in-range edges and queries with the odd
    // closure, plus some out-of-range indices and unused actions.
    task automatic run_phase(input logic [CFG_W-1:0] cnt, input int items,
                             input bit in_idle, input bit out_idle, input bit long_hold);
        t_graph_cmd c;
        int         n;
        int         j;
        int         pick;
        write_node_count(cnt);
        n = (cnt > MAX_NODES) ? MAX_NODES : int'(cnt);
        @(negedge i_clk);
        in_idle_on  = in_idle;
        out_idle_on = out_idle;
        for (j = 0; j < items; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                c.act = ACT_ADD;
            else if (pick < 55)
                c.act = ACT_CLOSE;
            else if (pick < 93)
                c.act = ACT_QUERY;
            else
                c.act = ACT_NONE;
            if (n > 0 && $urandom_range(0, 9) != 0) begin
                c.src = t_idx'($urandom_range(0, n - 1));
                c.dst = t_idx'($urandom_range(0, n - 1));
            end else begin
                c.src = t_idx'($urandom_range(0, MAX_NODES - 1));
                c.dst = t_idx'($urandom_range(0, MAX_NODES - 1));
            end
            pending_cmds.insert(pending_cmds.size(), c);
        end
        if (long_hold) begin
            hold_req = 1'b1;
            @(negedge i_clk);
            hold_req = 1'b0;
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.action    = ACT_NONE;
        cmd_if.src_node  = '0;
        cmd_if.dest_node = '0;
        res_if.ready     = 1'b0;
        hold_req         = 1'b0;
        in_idle_on       = 1'b0;
        out_idle_on      = 1'b0;
        mismatches       = 0;
        shadow_node_count = 6'd32;
        for (int i = 0; i < MAX_NODES; i++) begin
            shadow_adj[i]   = '0;
            shadow_reach[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed at the reset node_count: query before any closure, a
        // 3-node loop, self edges, a stale query, highest indices, unused action.
        push_cmd(ACT_QUERY, 0, 0);
        push_cmd(ACT_ADD, 0, 1);
        push_cmd(ACT_ADD, 1, 2);
        push_cmd(ACT_ADD, 2, 0);
        push_cmd(ACT_ADD, 31, 31);
        push_cmd(ACT_ADD, 31, 30);
        push_cmd(ACT_ADD, 30, 29);
        push_cmd(ACT_QUERY, 0, 2);      // stale, no closure yet
        push_cmd(ACT_CLOSE, 0, 0);
        push_cmd(ACT_QUERY, 0, 2);
        push_cmd(ACT_QUERY, 0, 0);      // self reach through the loop
        push_cmd(ACT_QUERY, 31, 29);
        push_cmd(ACT_QUERY, 31, 31);    // self edge was dropped
        push_cmd(ACT_QUERY, 29, 31);
        push_cmd(ACT_NONE, 31, 31);
        push_cmd(ACT_NONE, 0, 0);
        push_cmd(ACT_ADD, 2, 3);
        push_cmd(ACT_QUERY, 0, 3);      // stale again
        push_cmd(ACT_CLOSE, 31, 31);
        push_cmd(ACT_QUERY, 1, 3);
        wait_drained();

        // Shrink to 3 nodes: out-of-range indices, high rows left out of
        // the closure while their edges stay stored.
        write_node_count(6'd3);
        push_cmd(ACT_QUERY, 0, 2);
        push_cmd(ACT_QUERY, 2, 3);
        push_cmd(ACT_ADD, 3, 0);
        push_cmd(ACT_ADD, 1, 1);
        push_cmd(ACT_CLOSE, 0, 0);
        push_cmd(ACT_QUERY, 0, 0);
        wait_drained();

        // Random phases over the node_count range, extremes included;
        // node_count 0 puts every index out of range.
        run_phase(6'd0,  30,          1'b1, 1'b1, 1'b0);
        run_phase(6'd1,  PHASE_ITEMS, 1'b0, 1'b0, 1'b0);
        run_phase(6'd2,  PHASE_ITEMS, 1'b1, 1'b1, 1'b1);
        run_phase(6'd63, PHASE_ITEMS, 1'b1, 1'b0, 1'b0);
        run_phase(6'd7,  PHASE_ITEMS, 1'b0, 1'b1, 1'b1);
        run_phase(6'd33, PHASE_ITEMS, 1'b1, 1'b1, 1'b0);
        run_phase(6'd32, PHASE_ITEMS, 1'b0, 1'b0, 1'b1);
        run_phase(CFG_W'($urandom_range(0, 63)), PHASE_ITEMS, 1'b1, 1'b1, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_answers.size() != 0)
            flag_mismatch($sformatf("%0d result words never arrived",
                                    expected_answers.size()));
        if (mismatches == 0)
            $display("** graph_reachability_closure_core: PASSED **");
        else
            $display("** graph_reachability_closure_core: FAILED **");
        $finish;
    end

endmodule
